// ===== rtl/core/safs_pkg.sv =====
// Shared types and constants for the slot allocator with free stack.
package safs_pkg;

  localparam int SLOTS_DEF = 256;

  localparam int SLOT_W = 8;
  localparam int TYPE_W = 2;
  localparam int CAP_W  = 9;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [TYPE_W-1:0] TYPE_NULL = 2'd0;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

  // Operation strobes from the request sequencer to the free stack.
  typedef struct packed {
    logic fetch;  // register the current top entry
    logic push;
    logic pop;
  } stk_op_t;

endpackage

// ===== rtl/core/slot_allocator_free_stack.sv =====
// Top level: request sequencer, high-water counter and slot type memory.
//
// Slot allocator with slot 0 reserved. Each request (allocate or free) passes
// through an accept and an execute state: the accept cycle issues reads of the
// free-stack top and the slot type memory, and the execute state completes the
// read-modify-write and loads the result register once the output can take it.
// A new request is taken while a previous result still waits on the output, and
// the execute state holds only while that result has not yet been taken.
// Allocate pops the most recently freed slot, else takes the next never-used
// slot below min(capacity, SLOTS), else reports full with slot 0. Free of slot
// 0, of a slot never handed out, or of a slot typed null is ignored. The
// memories need no clearing after reset; unwritten entries are never used.
module slot_allocator_free_stack #(
  parameter int SLOTS = safs_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: capacity
  input  logic                          cfg_we,
  input  logic [safs_pkg::CAP_W-1:0]    cfg_wdata,
  // requests
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [7:0] slot_index, [9:8] obj_type
  input  logic                          s_tuser,   // kind
  // results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [safs_pkg::SLOT_W-1:0]   m_tdata,   // [7:0] slot
  output logic [safs_pkg::STAT_W-1:0]   m_tuser    // [1:0] status
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam int CMP_W = (CNT_W > safs_pkg::CAP_W) ? CNT_W : safs_pkg::CAP_W;
  localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  logic [safs_pkg::CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]            high_water;

  logic                        req_kind;
  logic [safs_pkg::SLOT_W-1:0] req_idx;
  logic [safs_pkg::TYPE_W-1:0] req_type;

  logic [safs_pkg::TYPE_W-1:0] type_mem [SLOTS];
  logic [safs_pkg::TYPE_W-1:0] type_rd;

  safs_pkg::stk_op_t           stk_op;
  logic [IDX_W-1:0]            stk_top;
  logic [CNT_W-1:0]            stk_depth;

  logic                        accept;
  logic                        go;
  logic [CMP_W-1:0]            hw_c;
  logic [CMP_W-1:0]            idx_c;
  logic [CMP_W-1:0]            limit;
  logic                        stk_empty;
  logic                        stk_full;
  logic                        cnt_full;
  logic                        alloc_pop;
  logic                        alloc_new;
  logic                        free_ok;
  logic [IDX_W-1:0]            alloc_slot;
  logic                        type_we;
  logic [IDX_W-1:0]            type_waddr;
  logic [safs_pkg::TYPE_W-1:0] type_wdata;
  logic [safs_pkg::SLOT_W-1:0] res_slot;
  logic [safs_pkg::STAT_W-1:0] res_status;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign go       = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= safs_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // request capture and type read
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= s_tuser;
      req_idx  <= s_tdata[7:0];
      req_type <= s_tdata[9:8];
      type_rd  <= type_mem[IDX_W'(s_tdata[7:0])];
    end
    if (type_we) begin
      type_mem[type_waddr] <= type_wdata;
    end
  end

  safs_free_stack #(
    .SLOTS (SLOTS)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .op        (stk_op),
    .push_data (IDX_W'(req_idx)),
    .top_data  (stk_top),
    .depth     (stk_depth)
  );

  always_comb begin
    hw_c      = CMP_W'(high_water);
    idx_c     = CMP_W'(req_idx);
    limit     = (CMP_W'(capacity) > SLOTS_C) ? SLOTS_C : CMP_W'(capacity);
    stk_empty = (stk_depth == '0);
    stk_full  = (CMP_W'(stk_depth) >= SLOTS_C);
    cnt_full  = (hw_c >= limit) || (hw_c >= SLOTS_C);
    alloc_pop = !stk_empty;
    alloc_new = stk_empty && !cnt_full;
    alloc_slot = alloc_pop ? stk_top : IDX_W'(high_water);
    free_ok   = !((req_idx == '0) || (idx_c >= hw_c) || (idx_c >= SLOTS_C) ||
                  (type_rd == safs_pkg::TYPE_NULL) || stk_full);

    if (req_kind == safs_pkg::KIND_FREE) begin
      res_slot   = req_idx;
      res_status = free_ok ? safs_pkg::ST_DONE : safs_pkg::ST_IGNORED;
      type_we    = go && free_ok;
      type_waddr = IDX_W'(req_idx);
      type_wdata = safs_pkg::TYPE_NULL;
    end else begin
      res_slot   = (alloc_pop || alloc_new) ? safs_pkg::SLOT_W'(alloc_slot) : '0;
      res_status = (alloc_pop || alloc_new) ? safs_pkg::ST_DONE : safs_pkg::ST_FULL;
      type_we    = go && (alloc_pop || alloc_new);
      type_waddr = alloc_slot;
      type_wdata = req_type;
    end

    stk_op.fetch = accept;
    stk_op.push  = go && (req_kind == safs_pkg::KIND_FREE) && free_ok;
    stk_op.pop   = go && (req_kind == safs_pkg::KIND_ALLOC) && alloc_pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= CNT_W'(1);
    end else if (go && (req_kind == safs_pkg::KIND_ALLOC) && alloc_new) begin
      high_water <= high_water + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_slot;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second request accepted while one is in flight");

  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    (high_water != '0) && (CMP_W'(high_water) <= SLOTS_C))
    else $error("high-water counter out of range");

  a_stack_below_hw: assert property (@(posedge clk) disable iff (rst)
    stk_depth < high_water)
    else $error("free stack holds more slots than were handed out");

  a_full_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == safs_pkg::ST_FULL)) |-> (m_tdata == '0))
    else $error("full status with nonzero slot");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_EXEC))
    else $error("result raised outside the execute cycle");

endmodule

// ===== rtl/core/safs_free_stack.sv =====
// LIFO of freed slot numbers in a single-port memory with a registered top read.
module safs_free_stack #(
  parameter int SLOTS = safs_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  safs_pkg::stk_op_t          op,
  input  logic [$clog2(SLOTS)-1:0]   push_data,
  output logic [$clog2(SLOTS)-1:0]   top_data,
  output logic [$clog2(SLOTS+1)-1:0] depth
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS+1);

  logic [IDX_W-1:0] mem [SLOTS];

  // top_data is valid the cycle after fetch; it holds until the next fetch
  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[IDX_W'(depth)] <= push_data;
    end
    if (op.fetch) begin
      top_data <= mem[IDX_W'(depth - CNT_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (op.push) begin
      depth <= depth + CNT_W'(1);
    end else if (op.pop) begin
      depth <= depth - CNT_W'(1);
    end
  end

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(op.push && op.pop))
    else $error("free stack push and pop in the same cycle");

  a_no_fetch_during_update: assert property (@(posedge clk) disable iff (rst)
    op.fetch |-> !(op.push || op.pop))
    else $error("free stack top fetched while depth changes");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    (!op.push || (depth < CNT_W'(SLOTS))) && (!op.pop || (depth != '0)))
    else $error("free stack overflow or underflow");

endmodule
